@@ design/adddt_pkg.sv @@
`timescale 1ns / 1ps

package adddt_pkg;

  localparam int DayW  = 5;
  localparam int MonW  = 4;
  localparam int YearW = 14;
  localparam int AddW  = 16;
  localparam int QuoW  = 8;
  localparam int RemW  = 7;
  localparam int ProdW = 27;

  // The year is split into year / 100 and year % 100 by a reciprocal multiply.
  localparam logic [ProdW-1:0] YearRecip = ProdW'(5243);
  localparam int               YearShift = 19;
  localparam logic [YearW-1:0] Century   = YearW'(100);
  localparam logic [RemW-1:0]  RemLast   = RemW'(99);

  localparam logic [MonW-1:0]  MonthJan = 4'd1;
  localparam logic [MonW-1:0]  MonthFeb = 4'd2;
  localparam logic [MonW-1:0]  MonthDec = 4'd12;

  typedef struct packed {
    logic load;
    logic div;
    logic rem;
    logic check;
    logic step;
    logic out_load;
  } adddt_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic bad;
  } adddt_status_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    unique case (m)
      4'd2:                     len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ design/adddt_dp.sv @@
`timescale 1ns / 1ps

module adddt_dp #(
  parameter int CntW = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  adddt_pkg::adddt_cmd_t             cmd_i,
  output adddt_pkg::adddt_status_t          status_o,
  input  logic [adddt_pkg::DayW-1:0]        start_day_i,
  input  logic [adddt_pkg::MonW-1:0]        start_month_i,
  input  logic [adddt_pkg::YearW-1:0]       start_year_i,
  input  logic [adddt_pkg::AddW-1:0]        days_to_add_i,
  output logic [adddt_pkg::DayW-1:0]        end_day_o,
  output logic [adddt_pkg::MonW-1:0]        end_month_o,
  output logic [adddt_pkg::YearW-1:0]       end_year_o,
  output logic                              bad_date_o
);

  logic [adddt_pkg::DayW-1:0]  d_q;
  logic [adddt_pkg::MonW-1:0]  m_q;
  logic [adddt_pkg::YearW-1:0] y_q;
  logic [CntW-1:0]             n_q;
  logic [adddt_pkg::QuoW-1:0]  q_q;
  logic [adddt_pkg::RemW-1:0]  r_q;
  logic                        bad_q;

  logic [adddt_pkg::DayW-1:0]  end_day_q;
  logic [adddt_pkg::MonW-1:0]  end_month_q;
  logic [adddt_pkg::YearW-1:0] end_year_q;
  logic                        bad_date_q;

  logic                        leap;
  logic [adddt_pkg::DayW-1:0]  len;
  logic                        bad_now;
  logic [adddt_pkg::DayW-1:0]  to_next;
  logic                        fits;
  logic [adddt_pkg::ProdW-1:0] prod;
  logic [adddt_pkg::YearW-1:0] cent;

  // A year is a leap year when it is divisible by 4 and either not a whole
  // century or a century divisible by 400.
  assign leap    = (y_q[1:0] == 2'd0) && ((r_q != '0) || (q_q[1:0] == 2'd0));
  assign len     = adddt_pkg::month_len(m_q, leap);
  assign bad_now = (m_q < adddt_pkg::MonthJan) || (m_q > adddt_pkg::MonthDec) ||
                   (d_q == '0) || (d_q > len);
  assign to_next = len - d_q + 5'd1;
  assign fits    = n_q < CntW'(to_next);
  assign prod    = adddt_pkg::ProdW'(y_q) * adddt_pkg::YearRecip;
  assign cent    = adddt_pkg::YearW'(q_q) * adddt_pkg::Century;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      d_q <= start_day_i;
      m_q <= start_month_i;
      y_q <= start_year_i;
      n_q <= days_to_add_i[CntW-1:0];
    end
    if (cmd_i.div) begin
      q_q <= prod[adddt_pkg::YearShift +: adddt_pkg::QuoW];
    end
    if (cmd_i.rem) begin
      r_q <= adddt_pkg::RemW'(y_q - cent);
    end
    if (cmd_i.check) begin
      bad_q <= bad_now;
    end
    if (cmd_i.step) begin
      if (!fits) begin
        n_q <= n_q - CntW'(to_next);
        d_q <= 5'd1;
        if (m_q == adddt_pkg::MonthDec) begin
          m_q <= adddt_pkg::MonthJan;
          y_q <= y_q + 14'd1;
          if (y_q == '1) begin
            r_q <= '0;
            q_q <= '0;
          end else if (r_q == adddt_pkg::RemLast) begin
            r_q <= '0;
            q_q <= q_q + 8'd1;
          end else begin
            r_q <= r_q + 7'd1;
          end
        end else begin
          m_q <= m_q + 4'd1;
        end
      end else begin
        d_q <= d_q + adddt_pkg::DayW'(n_q);
        n_q <= '0;
      end
    end
    if (cmd_i.out_load) begin
      end_day_q   <= d_q;
      end_month_q <= m_q;
      end_year_q  <= y_q;
      bad_date_q  <= bad_q;
    end
  end

  assign status_o.n_zero = (n_q == '0);
  assign status_o.bad    = bad_q;

  assign end_day_o   = end_day_q;
  assign end_month_o = end_month_q;
  assign end_year_o  = end_year_q;
  assign bad_date_o  = bad_date_q;

  a_step_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && (n_q != '0)) |=> (n_q < $past(n_q)))
    else $error("Day count did not shrink on a step.");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rem |=> (r_q <= adddt_pkg::RemLast))
    else $error("Year remainder out of range.");

  a_step_day_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && (n_q != '0)) |=> ((d_q != '0) && (d_q <= len)))
    else $error("Day left outside the month after a step.");

endmodule

@@ design/adddt_ctrl.sv @@
`timescale 1ns / 1ps

module adddt_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  adddt_pkg::adddt_status_t status_i,
  output adddt_pkg::adddt_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StRem,
    StCheck,
    StRun,
    StFin
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;
  logic   done;

  assign out_free   = !out_valid_q || out_ready_i;
  assign done       = status_i.bad || status_i.n_zero;
  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == StIdle) && in_valid_i;
    cmd_o.div      = (state_q == StDiv);
    cmd_o.rem      = (state_q == StRem);
    cmd_o.check    = (state_q == StCheck);
    cmd_o.step     = (state_q == StRun) && !done;
    cmd_o.out_load = (state_q == StFin) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle:  if (in_valid_i) state_q <= StDiv;
        StDiv:   state_q <= StRem;
        StRem:   state_q <= StCheck;
        StCheck: state_q <= StRun;
        StRun:   if (done) state_q <= StFin;
        StFin:   if (out_free) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StDiv))
    else $error("Accepted request did not start the year split.");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StFin) && out_valid_q && !out_ready_i) |=> (state_q == StFin))
    else $error("Result dropped while the output register was full.");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (out_valid_q && (state_q == StIdle)))
    else $error("Result load did not raise valid.");

endmodule

@@ design/add_days_to_date_core.sv @@
`timescale 1ns / 1ps
// Requests pass through the year split, the date check, the month-stepping loop (one
// month boundary per step) and the load of the result into the output register.
// A new request is taken only in idle, once the previous result has been loaded.
// A new request is taken while a finished result still waits in the output register.
// Reset clears the controller state and the output valid; datapath registers are not reset.
module add_days_to_date_core #(
  parameter int ADD_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [adddt_pkg::DayW-1:0]        start_day_i,
  input  logic [adddt_pkg::MonW-1:0]        start_month_i,
  input  logic [adddt_pkg::YearW-1:0]       start_year_i,
  input  logic [adddt_pkg::AddW-1:0]        days_to_add_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [adddt_pkg::DayW-1:0]        end_day_o,
  output logic [adddt_pkg::MonW-1:0]        end_month_o,
  output logic [adddt_pkg::YearW-1:0]       end_year_o,
  output logic                              bad_date_o
);

  localparam int CntW = (ADD_BITS < adddt_pkg::AddW) ? ADD_BITS : adddt_pkg::AddW;

  adddt_pkg::adddt_cmd_t    cmd;
  adddt_pkg::adddt_status_t status;

  adddt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  adddt_dp #(
    .CntW (CntW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .start_day_i   (start_day_i),
    .start_month_i (start_month_i),
    .start_year_i  (start_year_i),
    .days_to_add_i (days_to_add_i),
    .end_day_o     (end_day_o),
    .end_month_o   (end_month_o),
    .end_year_o    (end_year_o),
    .bad_date_o    (bad_date_o)
  );

endmodule

@@ bench/add_days_to_date_core_tb.sv @@
`timescale 1ns / 1ps

module add_days_to_date_core_tb;

  localparam int AddBits = 16;
  localparam int unsigned CycleLimit = 40_000_000;
  localparam int ItemsPerPhase = 440;
  localparam int SettleCycles = 2200;

  typedef struct packed {
    logic [adddt_pkg::DayW-1:0]  day;
    logic [adddt_pkg::MonW-1:0]  month;
    logic [adddt_pkg::YearW-1:0] year;
    logic                        bad;
  } date_result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [adddt_pkg::DayW-1:0]  start_day_i;
  logic [adddt_pkg::MonW-1:0]  start_month_i;
  logic [adddt_pkg::YearW-1:0] start_year_i;
  logic [adddt_pkg::AddW-1:0]  days_to_add_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [adddt_pkg::DayW-1:0]  end_day_o;
  logic [adddt_pkg::MonW-1:0]  end_month_o;
  logic [adddt_pkg::YearW-1:0] end_year_o;
  logic                        bad_date_o;

  date_result_t pending_dates[$];
  int           mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_tag = 0;
  int           hold_len = 0;

  add_days_to_date_core #(
    .ADD_BITS(AddBits)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .start_day_i   (start_day_i),
    .start_month_i (start_month_i),
    .start_year_i  (start_year_i),
    .days_to_add_i (days_to_add_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .end_day_o     (end_day_o),
    .end_month_o   (end_month_o),
    .end_year_o    (end_year_o),
    .bad_date_o    (bad_date_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit is_leap(logic [adddt_pkg::YearW-1:0] y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return (y % 4 == 0);
  endfunction

  function automatic int month_days(logic [adddt_pkg::MonW-1:0] m,
                                    logic [adddt_pkg::YearW-1:0] y);
    int days;
    if (m == adddt_pkg::MonthFeb) begin
      days = is_leap(y) ? 29 : 28;
    end else if (m == 4 || m == 6 || m == 9 || m == 11) begin
      days = 30;
    end else begin
      days = 31;
    end
    return days;
  endfunction

  function automatic date_result_t advance_date(logic [adddt_pkg::DayW-1:0] d,
                                                logic [adddt_pkg::MonW-1:0] m,
                                                logic [adddt_pkg::YearW-1:0] y,
                                                logic [adddt_pkg::AddW-1:0] n);
    date_result_t res;
    int unsigned  left;
    int unsigned  to_first;
    res.day = d;
    res.month = m;
    res.year = y;
    res.bad = 1'b0;
    left = 32'(n) & ((32'd1 << AddBits) - 1);
    if (m < adddt_pkg::MonthJan || m > adddt_pkg::MonthDec || d == 0 ||
        int'(d) > month_days(m, y)) begin
      res.bad = 1'b1;
      return res;
    end
    while (left > 0) begin
      to_first = month_days(res.month, res.year) - res.day + 1;
      if (left >= to_first) begin
        left -= to_first;
        res.day = adddt_pkg::DayW'(1);
        if (res.month == adddt_pkg::MonthDec) begin
          res.month = adddt_pkg::MonthJan;
          res.year = res.year + 1'b1;
        end else begin
          res.month = res.month + 1'b1;
        end
      end else begin
        res.day = res.day + adddt_pkg::DayW'(left);
        left = 0;
      end
    end
    return res;
  endfunction

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
  initial begin
    int seen_tag;
    int hold_left;
    seen_tag = 0;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_tag != seen_tag) begin
        seen_tag = hold_tag;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    date_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_dates.size() == 0) begin
        $error("unexpected result: day %0d month %0d year %0d bad %0d",
               end_day_o, end_month_o, end_year_o, bad_date_o);
        mismatch_count++;
      end else begin
        want = pending_dates.pop_front();
        if (end_day_o !== want.day) begin
          $error("end_day: expected %0d, got %0d", want.day, end_day_o);
          mismatch_count++;
        end
        if (end_month_o !== want.month) begin
          $error("end_month: expected %0d, got %0d", want.month, end_month_o);
          mismatch_count++;
        end
        if (end_year_o !== want.year) begin
          $error("end_year: expected %0d, got %0d", want.year, end_year_o);
          mismatch_count++;
        end
        if (bad_date_o !== want.bad) begin
          $error("bad_date: expected %0d, got %0d", want.bad, bad_date_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_date(logic [adddt_pkg::DayW-1:0] d, logic [adddt_pkg::MonW-1:0] m,
                           logic [adddt_pkg::YearW-1:0] y, logic [adddt_pkg::AddW-1:0] n);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    start_day_i   <= d;
    start_month_i <= m;
    start_year_i  <= y;
    days_to_add_i <= n;
    do @(posedge clk_i); while (!in_ready_o);
    pending_dates.push_back(advance_date(d, m, y, n));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_zero_days();
    send_date(5'd15, 4'd6, 14'd2023, 16'd0);
    send_date(5'd31, adddt_pkg::MonthDec, 14'd16383, 16'd0);
    wait_drained();
  endtask

  task automatic test_invalid_dates();
    send_date(5'd10, 4'd0, 14'd2020, 16'd5);
    send_date(5'd10, 4'd13, 14'd2020, 16'd5);
    send_date(5'd31, 4'd15, 14'd16383, 16'hFFFF);
    send_date(5'd0, adddt_pkg::MonthJan, 14'd2020, 16'd1);
    send_date(5'd31, 4'd4, 14'd2021, 16'd1);
    send_date(5'd29, adddt_pkg::MonthFeb, 14'd1900, 16'd1);
    send_date(5'd30, adddt_pkg::MonthFeb, 14'd2000, 16'd1);
    wait_drained();
  endtask

  task automatic test_leap_years();
    send_date(5'd28, adddt_pkg::MonthFeb, 14'd2000, 16'd1);
    send_date(5'd28, adddt_pkg::MonthFeb, 14'd1900, 16'd1);
    send_date(5'd28, adddt_pkg::MonthFeb, 14'd2024, 16'd1);
    send_date(5'd28, adddt_pkg::MonthFeb, 14'd2023, 16'd1);
    send_date(5'd29, adddt_pkg::MonthFeb, 14'd2000, 16'd365);
    send_date(5'd28, adddt_pkg::MonthFeb, 14'd0, 16'd1);
    wait_drained();
  endtask

  task automatic test_year_wrap();
    send_date(5'd31, adddt_pkg::MonthDec, 14'd16383, 16'd1);
    send_date(5'd1, adddt_pkg::MonthJan, 14'd16383, 16'hFFFF);
    send_date(5'd31, adddt_pkg::MonthDec, 14'd9999, 16'd1);
    wait_drained();
  endtask

  task automatic test_month_edges();
    send_date(5'd1, adddt_pkg::MonthJan, 14'd1, 16'hFFFF);
    send_date(5'd1, adddt_pkg::MonthJan, 14'd2021, 16'd30);
    send_date(5'd1, adddt_pkg::MonthJan, 14'd2021, 16'd31);
    send_date(5'd31, adddt_pkg::MonthJan, 14'd2021, 16'd1);
    wait_drained();
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    hold_len = 400;
    hold_tag++;
    for (int i = 0; i < 12; i++) begin
      send_date(adddt_pkg::DayW'($urandom_range(28, 1)),
                adddt_pkg::MonW'($urandom_range(12, 1)),
                adddt_pkg::YearW'($urandom_range(9999, 1)),
                adddt_pkg::AddW'($urandom_range(60, 0)));
    end
    wait_drained();
  endtask

  task automatic random_request();
    logic [adddt_pkg::DayW-1:0]  d;
    logic [adddt_pkg::MonW-1:0]  m;
    logic [adddt_pkg::YearW-1:0] y;
    logic [adddt_pkg::AddW-1:0]  n;
    int                          pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      d = adddt_pkg::DayW'($urandom);
      m = adddt_pkg::MonW'($urandom);
      y = adddt_pkg::YearW'($urandom);
    end else begin
      m = adddt_pkg::MonW'($urandom_range(12, 1));
      if (pick < 18) begin
        y = adddt_pkg::YearW'($urandom_range(16383, 16376));
      end else if (pick < 35) begin
        y = adddt_pkg::YearW'($urandom_range(16383, 0));
      end else begin
        y = adddt_pkg::YearW'($urandom_range(9999, 1));
      end
      d = adddt_pkg::DayW'($urandom_range(month_days(m, y), 1));
    end
    pick = $urandom_range(99);
    if (pick < 5) begin
      n = adddt_pkg::AddW'($urandom_range(31, 0));
    end else if (pick < 85) begin
      n = adddt_pkg::AddW'($urandom_range(400, 0));
    end else if (pick < 97) begin
      n = adddt_pkg::AddW'($urandom_range(4000, 0));
    end else begin
      n = adddt_pkg::AddW'($urandom);
    end
    send_date(d, m, y, n);
  endtask

  task automatic test_random_traffic();
    int idle_pct[4];
    int stall_pct[4];
    idle_pct = '{0, 70, 0, 10};
    stall_pct = '{0, 0, 70, 10};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      for (int i = 0; i < ItemsPerPhase; i++) begin
        random_request();
      end
      wait_drained();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    start_day_i = '0;
    start_month_i = '0;
    start_year_i = '0;
    days_to_add_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_zero_days();
    test_invalid_dates();
    test_leap_years();
    test_year_wrap();
    test_month_edges();
    test_output_backpressure();
    test_random_traffic();

    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/adddt_pkg.sv
design/adddt_dp.sv
design/adddt_ctrl.sv
design/add_days_to_date_core.sv
bench/add_days_to_date_core_tb.sv
